[hdl/rbcg_pkg.sv]
// Shared constants, types and elaboration-time tables for the brightness/contrast/gain block.
package rbcg_pkg;

    localparam int CH_W = 8;
    localparam int NL_W = 23;                  // -log2(u) in Q20
    localparam int PRD_W = 31;                 // contrast * nl
    localparam int T_W = 25;                   // exponent t in Q20
    localparam int R_W = 31;                   // power in Q30, up to 1.0
    localparam int K_W = 30;                   // root constants in Q30
    localparam int HEAD_BITS = 8;              // fraction bits resolved by table
    localparam int TAIL_BITS = 20 - HEAD_BITS; // fraction bits resolved by multiply stages
    localparam logic [31:0] RECIP_100 = 32'd2748779070; // ceil(2^38 / 100)
    localparam int RECIP_100_SH = 38;
    localparam logic [15:0] RECIP_50 = 16'd41944;       // ceil(2^21 / 50)
    localparam int RECIP_50_SH = 21;

    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_CONTRAST   = 3'd1;
    localparam logic [2:0] REG_RED_GAIN   = 3'd2;
    localparam logic [2:0] REG_GREEN_GAIN = 3'd3;
    localparam logic [2:0] REG_BLUE_GAIN  = 3'd4;

    typedef logic [127:0][NL_W-1:0] nl_tbl_t;
    typedef logic [255:0][R_W-1:0] head_tbl_t;
    typedef logic [20:1][K_W-1:0] k_tbl_t;

    // sideband that travels with the power through the multiply stages
    typedef struct packed {
        logic                 low;   // v <= 127
        logic                 zero;  // d == 0
        logic [4:0]           ip;    // integer part of t
        logic [TAIL_BITS-1:0] f;     // remaining fraction bits of t
    } side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_w;
        x = x_in;
        res = 64'd0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 64'd0) begin
            if (x >= res + bit_w) begin
                x = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q20(input logic [7:0] n);
        int k;
        logic [63:0] m;
        logic [63:0] frac;
        k = 0;
        frac = 64'd0;
        while (k < 7 && (n >> (k + 1)) != 8'd0) k++;
        m = 64'(n) << (30 - k);
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k) << 20) | frac;
    endfunction

    function automatic nl_tbl_t build_nl_tbl();
        nl_tbl_t tbl;
        logic [63:0] a;
        logic [63:0] b;
        tbl = '0;
        a = log2_q20(8'd255);
        for (int d = 1; d < 128; d++) begin
            b = log2_q20(8'(2 * d));
            tbl[d] = (a > b) ? NL_W'(a - b) : '0;
        end
        return tbl;
    endfunction

    function automatic k_tbl_t build_k_tbl();
        k_tbl_t tbl;
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 1; i <= 20; i++) begin
            c = isqrt64(c << 30);
            tbl[i] = K_W'(c);
        end
        return tbl;
    endfunction

    localparam nl_tbl_t NL_TBL = build_nl_tbl();
    localparam k_tbl_t K_TBL = build_k_tbl();

    function automatic head_tbl_t build_head_tbl();
        head_tbl_t tbl;
        logic [63:0] r;
        for (int idx = 0; idx < 256; idx++) begin
            r = 64'd1 << 30;
            for (int i = 1; i <= HEAD_BITS; i++) begin
                if (((idx >> (HEAD_BITS - i)) & 1) != 0)
                    r = (r * 64'(K_TBL[i])) >> 30;
            end
            tbl[idx] = R_W'(r);
        end
        return tbl;
    endfunction

    localparam head_tbl_t HEAD_TBL = build_head_tbl();

endpackage

[hdl/rbcg_exp_stage.sv]
// One multiply stage of the 2^-t power: applies one fraction bit.
module rbcg_exp_stage import rbcg_pkg::*; #(
    parameter int IDX = 9
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [R_W-1:0] r_in,
    input  side_t          side_in,
    output logic [R_W-1:0] r_out,
    output side_t          side_out
);
    logic [R_W+K_W-1:0] prod;
    logic [R_W-1:0]     r_next;

    assign prod = (R_W+K_W)'(r_in) * (R_W+K_W)'(K_TBL[IDX]);
    assign r_next = side_in.f[20-IDX] ? R_W'(prod >> 30) : r_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_out <= r_next;
            side_out <= side_in;
        end
    end
endmodule

[hdl/rbcg_channel.sv]
// Datapath of one color channel: brightness, contrast curve, gain.
module rbcg_channel import rbcg_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  logic [CH_W-1:0] c_in,
    input  logic [6:0]      brightness,
    input  logic [7:0]      contrast,
    input  logic [6:0]      gain,
    output logic [CH_W-1:0] c_out
);
    // stage 1: brightness offset, clamp, fold
    logic signed [9:0] s_sum;
    logic [7:0]        v;
    logic [6:0]        d1_reg;
    logic              low1_reg;
    // stage 2: contrast * nl
    logic [PRD_W-1:0]  prd2_reg;
    logic              low2_reg, zero2_reg;
    // stage 3: divide by 100
    logic [PRD_W+31:0] q3;
    logic [T_W-1:0]    t3_reg;
    logic              low3_reg, zero3_reg;
    // stage 4 and tail
    logic [R_W-1:0]    r0_reg;
    side_t             side0_reg;
    logic [R_W-1:0]    r_pipe [TAIL_BITS+1];
    side_t             side_pipe [TAIL_BITS+1];
    // curve output
    side_t             sd;
    logic [R_W-1:0]    r_sh;
    logic [20:0]       p;
    logic [28:0]       p255;
    logic [28:0]       wv;
    logic [7:0]        w_reg;
    // gain
    logic [14:0]       g_reg;
    logic [30:0]       gq;
    logic [9:0]        gdiv;

    assign s_sum = 10'(signed'({2'b00, c_in})) + 10'(signed'({3'b000, brightness})) - 10'sd50;
    assign v = (s_sum < 0) ? 8'd0 : (s_sum > 10'sd255) ? 8'd255 : s_sum[7:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            low1_reg <= (v <= 8'd127);
            d1_reg <= (v <= 8'd127) ? v[6:0] : 7'(8'd255 - v);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prd2_reg <= PRD_W'(contrast) * PRD_W'(NL_TBL[d1_reg]);
            low2_reg <= low1_reg;
            zero2_reg <= (d1_reg == 7'd0);
        end
    end

    assign q3 = (PRD_W+32)'(prd2_reg) * (PRD_W+32)'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_reg <= T_W'(q3 >> RECIP_100_SH);
            low3_reg <= low2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // table covers the top fraction bits
    always_ff @(posedge aclk) begin
        if (en) begin
            r0_reg <= HEAD_TBL[t3_reg[19:20-HEAD_BITS]];
            side0_reg.low <= low3_reg;
            side0_reg.zero <= zero3_reg;
            side0_reg.ip <= t3_reg[T_W-1:20];
            side0_reg.f <= t3_reg[TAIL_BITS-1:0];
        end
    end

    assign r_pipe[0] = r0_reg;
    assign side_pipe[0] = side0_reg;

    for (genvar i = 0; i < TAIL_BITS; i++) begin : g_exp
        rbcg_exp_stage #(.IDX(HEAD_BITS + 1 + i)) u_stage (
            .aclk     (aclk),
            .en       (en),
            .r_in     (r_pipe[i]),
            .side_in  (side_pipe[i]),
            .r_out    (r_pipe[i+1]),
            .side_out (side_pipe[i+1])
        );
    end

    assign sd = side_pipe[TAIL_BITS];
    assign r_sh = r_pipe[TAIL_BITS] >> sd.ip;
    assign p = sd.zero ? ((contrast == 8'd0) ? 21'd1 << 20 : 21'd0) : 21'(r_sh >> 10);
    assign p255 = 29'(p) * 29'd255;
    assign wv = sd.low ? p255 : ((29'd255 << 21) - p255);

    always_ff @(posedge aclk) begin
        if (en) w_reg <= 8'(wv >> 21);
    end

    always_ff @(posedge aclk) begin
        if (en) g_reg <= 15'(w_reg) * 15'(gain);
    end

    assign gq = 31'(g_reg) * 31'(RECIP_50);
    assign gdiv = 10'(gq >> RECIP_50_SH);

    always_ff @(posedge aclk) begin
        if (en) c_out <= (gdiv > 10'd255) ? 8'd255 : gdiv[7:0];
    end
endmodule

[hdl/rgb_brightness_contrast_gain.sv]
// Top level: BGR pixel brightness, S-curve contrast and per-channel gain.
//
// One BGR pixel word enters on the s_ channel (s_valid/s_ready) and the
// adjusted pixel word leaves on the m_ channel (m_valid/m_ready).
// Settings are written through cfg_wr_en/cfg_index/cfg_wdata:
//   0 brightness, 1 contrast, 2 red gain, 3 green gain, 4 blue gain;
//   other indexes are dropped. Write them only while the pipe is empty.
// Throughput: one word per cycle while m_ready does not stall the pipe,
// set by the 19-stage pipe with at most one multiplier per stage per
// channel (12 of those stages walk the low fraction bits of the contrast power).
// The three channels run in parallel, one copy of the datapath each.
// Reset (aresetn low, synchronous) empties the pipe and loads the defaults
// brightness 50, contrast 100, gains 50 (unity).
// When the receiver holds m_ready low with a word on the output, the whole
// pipe freezes and s_ready drops; nothing is lost or repeated.
module rgb_brightness_contrast_gain import rbcg_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CH_W-1:0] s_blue_in,
    input  logic [CH_W-1:0] s_green_in,
    input  logic [CH_W-1:0] s_red_in,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CH_W-1:0] m_blue_out,
    output logic [CH_W-1:0] m_green_out,
    output logic [CH_W-1:0] m_red_out,
    input  logic            cfg_wr_en,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_wdata
);
    localparam int LAT = TAIL_BITS + 7;

    logic [6:0]     brightness_reg;
    logic [7:0]     contrast_reg;
    logic [6:0]     red_gain_reg, green_gain_reg, blue_gain_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;

    // pipe moves whenever the output slot is free or being drained
    assign en = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 7'd50;
            contrast_reg <= 8'd100;
            red_gain_reg <= 7'd50;
            green_gain_reg <= 7'd50;
            blue_gain_reg <= 7'd50;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_wdata[6:0];
                REG_CONTRAST:   contrast_reg <= cfg_wdata;
                REG_RED_GAIN:   red_gain_reg <= cfg_wdata[6:0];
                REG_GREEN_GAIN: green_gain_reg <= cfg_wdata[6:0];
                REG_BLUE_GAIN:  blue_gain_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    rbcg_channel u_blue (
        .aclk(aclk), .en(en), .c_in(s_blue_in), .brightness(brightness_reg),
        .contrast(contrast_reg), .gain(blue_gain_reg), .c_out(m_blue_out)
    );
    rbcg_channel u_green (
        .aclk(aclk), .en(en), .c_in(s_green_in), .brightness(brightness_reg),
        .contrast(contrast_reg), .gain(green_gain_reg), .c_out(m_green_out)
    );
    rbcg_channel u_red (
        .aclk(aclk), .en(en), .c_in(s_red_in), .brightness(brightness_reg),
        .contrast(contrast_reg), .gain(red_gain_reg), .c_out(m_red_out)
    );
endmodule

[dv/tb_top.sv]
// Self-checking testbench for the brightness, contrast and gain pixel pipe.
`timescale 1ns / 100ps

module tb_top import rbcg_pkg::*; ();

    localparam int PIPE_LAT = 19;
    localparam int RANDOM_WORDS = 600;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // one directed row: input pixel, and an optional typed-in expectation
    typedef struct {
        pixel_t pix;
        bit     known;
        pixel_t want;
    } pix_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_blue_in, s_green_in, s_red_in;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_blue_out, m_green_out, m_red_out;
    logic       cfg_wr_en;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;

    rgb_brightness_contrast_gain dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_blue_in(s_blue_in), .s_green_in(s_green_in), .s_red_in(s_red_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_blue_out(m_blue_out), .m_green_out(m_green_out), .m_red_out(m_red_out),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor's own copy of the settings
    logic [6:0] set_bright;
    logic [7:0] set_contrast;
    logic [6:0] set_rgain, set_ggain, set_bgain;

    pixel_t pixel_fifo[$];   // adjusted pixels still owed by the block
    int     mismatches;
    bit     quiet_out;       // receiver never stalls near the end
    int     stall_left;      // cycles left in the current receiver stall

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // log2(n) in Q20 by repeated squaring of the mantissa
    function automatic longint unsigned log2_fix(int unsigned n);
        int k;
        longint unsigned m, frac;
        k = 0;
        frac = 0;
        while (k < 7 && (n >> (k + 1)) != 0) k++;
        m = longint'(n) << (30 - k);
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 20) | frac;
    endfunction

    // 2^-t, t and result in Q20
    function automatic longint unsigned pow2_neg(longint unsigned t);
        longint unsigned r, c;
        r = 64'd1 << 30;
        c = 64'd1 << 29;
        for (int i = 1; i <= 20; i++) begin
            c = int_sqrt(c << 30);
            if (((t >> (20 - i)) & 1) != 0) r = (r * c) >> 30;
        end
        if ((t >> 20) >= 31) r = 0;
        else r = r >> (t >> 20);
        return r >> 10;
    endfunction

    function automatic int unsigned s_curve(int unsigned v);
        int unsigned d;
        longint unsigned p, a, b, nl;
        d = (v <= 127) ? v : 255 - v;
        if (d == 0) begin
            p = (set_contrast == 0) ? (64'd1 << 20) : 0;
        end else begin
            a = log2_fix(255);
            b = log2_fix(2 * d);
            nl = (a > b) ? a - b : 0;
            p = pow2_neg((longint'(set_contrast) * nl) / 100);
        end
        if (v <= 127) return int'((255 * p) >> 21);
        return int'(((64'd255 << 21) - 255 * p) >> 21);
    endfunction

    function automatic logic [7:0] adjust_channel(logic [7:0] c, logic [6:0] gain);
        int s;
        int unsigned g;
        s = int'(c) + int'(set_bright) - 50;
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        g = (s_curve(s) * gain) / 50;
        return (g > 255) ? 8'd255 : g[7:0];
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t p);
        pixel_t q;
        q.blue  = adjust_channel(p.blue, set_bgain);
        q.green = adjust_channel(p.green, set_ggain);
        q.red   = adjust_channel(p.red, set_rgain);
        return q;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        pixel_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_blue_out, m_green_out, m_red_out};
                if (pixel_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word b=%0d g=%0d r=%0d",
                                 got.blue, got.green, got.red);
                end else begin
                    want = pixel_fifo.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                                     want.blue, want.green, want.red,
                                     got.blue, got.green, got.red);
                    end
                end
            end
            // receiver stalls in bursts of random length
            if (quiet_out) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BRIGHTNESS: set_bright   = val[6:0];
            REG_CONTRAST:   set_contrast = val;
            REG_RED_GAIN:   set_rgain    = val[6:0];
            REG_GREEN_GAIN: set_ggain    = val[6:0];
            REG_BLUE_GAIN:  set_bgain    = val[6:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // wait for all owed words, then let the pipe settle before a write
    task automatic drain_pipe();
        while (pixel_fifo.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    // offer one word; valid stays up across back-to-back words
    task automatic send_pixel(pixel_t p, bit gaps);
        int idle;
        if (gaps && $urandom_range(0, 4) == 0) begin
            idle = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_blue_in  <= p.blue;
        s_green_in <= p.green;
        s_red_in   <= p.red;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixel_fifo.push_back(adjust_pixel(p));
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = 24'($urandom);
        return p;
    endfunction

    // ---------------- main sequence ----------------

    pix_row_t rows[$];

    initial begin
        pixel_t got_exp;
        int phase;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_blue_in  = '0;
        s_green_in = '0;
        s_red_in   = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        quiet_out  = 1'b0;
        mismatches = 0;
        set_bright = 7'd50;
        set_contrast = 8'd100;
        set_rgain = 7'd50;
        set_ggain = 7'd50;
        set_bgain = 7'd50;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset settings: black and white stay put
        rows.push_back('{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}});
        rows.push_back('{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}});
        rows.push_back('{'{8'd127, 8'd128, 8'd1}, 1'b0, '0});
        rows.push_back('{'{8'd254, 8'd64, 8'd192}, 1'b0, '0});
        rows.push_back('{'{8'haa, 8'h55, 8'h0f}, 1'b0, '0});
        rows.push_back('{'{8'h55, 8'haa, 8'hf0}, 1'b0, '0});
        foreach (rows[i]) begin
            send_pixel(rows[i].pix, 1'b0);
            if (rows[i].known) begin
                got_exp = pixel_fifo[$];
                if (got_exp !== rows[i].want) begin
                    mismatches++;
                    $display("directed row %0d: predictor disagrees with table", i);
                end
                pixel_fifo[$] = rows[i].want;
            end
        end
        end_burst();
        drain_pipe();

        // zero contrast: base zero taken as one, flat mid gray elsewhere
        write_reg(REG_CONTRAST, 8'd0);
        write_reg(REG_BRIGHTNESS, 8'd0);
        send_pixel('{8'd0, 8'd50, 8'd255}, 1'b0);
        end_burst();
        drain_pipe();

        // top extremes, out-of-range register values, ignored index
        write_reg(REG_CONTRAST, 8'd255);
        write_reg(REG_BRIGHTNESS, 8'd127);
        write_reg(REG_RED_GAIN, 8'd127);
        write_reg(REG_GREEN_GAIN, 8'd0);
        write_reg(REG_BLUE_GAIN, 8'd100);
        write_reg(3'd5, 8'hff);
        write_reg(3'd7, 8'h00);
        send_pixel('{8'd0, 8'd128, 8'd255}, 1'b0);
        send_pixel('{8'd10, 8'd100, 8'd200}, 1'b0);
        end_burst();
        drain_pipe();
        write_reg(REG_BRIGHTNESS, 8'd100);
        write_reg(REG_CONTRAST, 8'd200);
        write_reg(REG_RED_GAIN, 8'd100);
        send_pixel('{8'd77, 8'd127, 8'd128}, 1'b0);
        end_burst();
        drain_pipe();

        // random phases with fresh settings; full byte range on contrast, 0xff once on brightness and red gain
        for (phase = 0; phase < 6; phase++) begin
            write_reg(REG_BRIGHTNESS, (phase == 0) ? 8'hff : 8'($urandom_range(0, 127)));
            write_reg(REG_CONTRAST, 8'($urandom_range(0, 255)));
            write_reg(REG_RED_GAIN, (phase == 0) ? 8'hff : 8'($urandom_range(0, 127)));
            write_reg(REG_GREEN_GAIN, 8'($urandom_range(0, 127)));
            write_reg(REG_BLUE_GAIN, 8'($urandom_range(0, 127)));
            for (int n = 0; n < RANDOM_WORDS / 6; n++) begin
                if (phase == 5 && n == RANDOM_WORDS / 12) quiet_out = 1'b1;
                send_pixel(rand_pixel(), !quiet_out);
                // sender holds off until every owed word is back
                if (phase == 2 && n == 40) begin
                    end_burst();
                    while (pixel_fifo.size() != 0) @(posedge aclk);
                end
            end
            end_burst();
            drain_pipe();
        end

        if (mismatches == 0 && pixel_fifo.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/rbcg_pkg.sv
hdl/rbcg_exp_stage.sv
hdl/rbcg_channel.sv
hdl/rgb_brightness_contrast_gain.sv
dv/tb_top.sv
